// ===== hdl/bps_pkg.sv =====
// bps_pkg: shared types, codes and coefficient functions for the path smoother
// depends on nothing; imported by bezier_path_smoother
`default_nettype none

package bps_pkg;

    // kind of work held in the issue stage
    typedef enum logic [1:0] {
        M_LONE,
        M_PAIR,
        M_SEG
    } t_mode;

    // points buffered in the current path
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    // weight of (p3 - p0), scaled to the common denominator 6*n^3
    function automatic int coef_a(input int n, input int s, input logic first);
        int w;
        if (first) begin
            w = 6 * n * n * s;
        end else begin
            w = 6 * s * s * (3 * n - 2 * s);
        end
        return w;
    endfunction

    // weight of (p3 - prev), same denominator
    function automatic int coef_b(input int n, input int s, input logic first);
        int w;
        if (first) begin
            w = 0;
        end else begin
            w = 3 * s * (n - s) * (n - 2 * s);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bezier_path_smoother.sv =====
// bezier_path_smoother: streaming cubic bezier path smoother, one sample per cycle
// uses bps_pkg (mode enum, point count codes, coefficient functions)
// the one-sample-per-cycle rate holds only while the output is not stalled by i_out_ready
// results per point: inner point SAMPLES, final point SAMPLES+1,
// 2 for the end of a two-point path, 1 for a lone point, 0 for a buffered first point
// reset: clears point count, point history, issue stage and pipeline valids
`default_nettype none

module bezier_path_smoother #(
    parameter int SAMPLES     = 5,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    input  logic signed [COORD_WIDTH-1:0] i_in_z,
    input  logic                          i_in_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic                          o_run_last,
    output logic                          o_path_end
);
    import bps_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int DEN   = 6 * SAMPLES * SAMPLES * SAMPLES;
    localparam int HDEN  = DEN / 2;
    localparam int KW    = $clog2(DEN + 1) + 1;
    localparam int DW    = W + 1;
    localparam int PW    = KW + DW;
    localparam int MW    = PW;
    localparam int LW    = MW / 2;
    localparam int HW    = MW - LW;
    localparam int QW    = W + 2;
    localparam int CW    = QW + KW;
    localparam int CNW   = $clog2(SAMPLES + 1);
    localparam logic [MW-1:0] RECIP =
        MW'((((MW + 1)'(1'b1)) << MW) / (MW + 1)'(DEN) + 1'b1);
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W - 1){1'b0}}};

    logic signed [W-1:0] in_pt [3];

    assign in_pt[0] = i_in_x;
    assign in_pt[1] = i_in_y;
    assign in_pt[2] = i_in_z;

    // point history and issue stage
    logic [1:0]           r_seen;
    logic [1:0]           n_seen;
    logic signed [W-1:0]  r_older [3];
    logic signed [W-1:0]  r_newer [3];
    logic                 r_busy;
    t_mode                r_mode;
    t_mode                n_mode;
    logic [CNW-1:0]       r_cnt;
    logic                 r_first;
    logic                 r_last;
    logic signed [W-1:0]  r_prev [3];
    logic signed [W-1:0]  r_p0 [3];
    logic signed [W-1:0]  r_p3 [3];
    logic                 n_load;
    logic                 n_shift;
    logic                 n_buf;

    logic                 adv;
    logic                 issue;
    logic                 accept;
    logic signed [KW-1:0] iss_a;
    logic signed [KW-1:0] iss_b;
    logic                 iss_rl;
    logic                 iss_pe;
    logic                 iss_done;
    logic                 iss_from_p3;

    // pipeline
    logic [6:0]           r_vld;
    logic [6:0]           r_rl;
    logic [6:0]           r_pe;
    logic signed [W-1:0]  r_base [6][3];
    logic [2:0]           r_neg [4];
    logic signed [KW-1:0] r_s1_a;
    logic signed [KW-1:0] r_s1_b;
    logic signed [DW-1:0] r_s1_d03 [3];
    logic signed [DW-1:0] r_s1_dp [3];
    logic signed [PW-1:0] r_s2_pa [3];
    logic signed [PW-1:0] r_s2_pb [3];
    logic [MW-1:0]        r_s3_mag [3];
    logic [HW+MW-1:0]     r_s4_ph [3];
    logic [LW+MW-1:0]     r_s4_pl [3];
    logic [MW-1:0]        r_s4_mag [3];
    logic [QW-1:0]        r_s5_qe [3];
    logic [MW-1:0]        r_s5_mag [3];
    logic [QW-1:0]        r_s6_q [3];
    logic signed [W-1:0]  r_out [3];

    logic signed [PW:0]   n_sum [3];
    logic [PW:0]          n_abs [3];
    logic [2:0]           n_neg;
    logic [MW-1:0]        n_mag [3];
    logic [2*MW-1:0]      n_acc [3];
    logic [QW-1:0]        n_qe [3];
    logic [CW-1:0]        n_chk [3];
    logic [QW-1:0]        n_q [3];
    logic signed [QW:0]   n_qs [3];
    logic signed [QW+1:0] n_tot [3];
    logic signed [W-1:0]  n_out [3];

    assign adv        = !r_vld[6] || i_out_ready;
    assign issue      = r_busy && adv;
    assign o_in_ready = !r_busy || (issue && iss_done);
    assign accept     = i_in_valid && o_in_ready;

    // what an accepted point does to the history and the issue stage
    always_comb begin
        n_seen  = r_seen;
        n_mode  = M_SEG;
        n_load  = 1'b0;
        n_shift = 1'b0;
        n_buf   = 1'b0;
        if (accept) begin
            unique case (r_seen)
                SEEN_NONE: begin
                    if (i_in_last) begin
                        n_load = 1'b1;
                        n_mode = M_LONE;
                    end else begin
                        n_buf  = 1'b1;
                        n_seen = SEEN_ONE;
                    end
                end
                SEEN_ONE: begin
                    n_load = 1'b1;
                    if (i_in_last) begin
                        n_mode = M_PAIR;
                        n_seen = SEEN_NONE;
                    end else begin
                        n_shift = 1'b1;
                        n_seen  = SEEN_TWO;
                    end
                end
                SEEN_TWO: begin
                    n_load  = 1'b1;
                    n_shift = 1'b1;
                    n_seen  = i_in_last ? SEEN_NONE : SEEN_TWO;
                end
                default: begin
                    n_seen = SEEN_NONE;
                end
            endcase
        end
    end

    // one result per cycle from the issue stage while the pipeline advances
    always_comb begin
        iss_a       = '0;
        iss_b       = '0;
        iss_rl      = 1'b0;
        iss_pe      = 1'b0;
        iss_done    = 1'b0;
        iss_from_p3 = 1'b0;
        unique case (r_mode)
            M_LONE: begin
                iss_from_p3 = 1'b1;
                iss_rl      = 1'b1;
                iss_pe      = 1'b1;
                iss_done    = 1'b1;
            end
            M_PAIR: begin
                if (r_cnt != CNW'(0)) begin
                    iss_from_p3 = 1'b1;
                    iss_rl      = 1'b1;
                    iss_pe      = 1'b1;
                    iss_done    = 1'b1;
                end
            end
            M_SEG: begin
                if (r_cnt == CNW'(SAMPLES)) begin
                    iss_from_p3 = 1'b1;
                    iss_rl      = 1'b1;
                    iss_pe      = 1'b1;
                    iss_done    = 1'b1;
                end else begin
                    iss_a    = KW'(coef_a(SAMPLES, int'(r_cnt), r_first));
                    iss_b    = KW'(coef_b(SAMPLES, int'(r_cnt), r_first));
                    iss_rl   = (r_cnt == CNW'(SAMPLES - 1)) && !r_last;
                    iss_done = iss_rl;
                end
            end
            default: begin
                iss_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= SEEN_NONE;
            r_busy <= 1'b0;
            r_mode <= M_LONE;
            r_cnt  <= '0;
        end else begin
            r_seen <= n_seen;
            if (n_load) begin
                r_busy <= 1'b1;
                r_mode <= n_mode;
                r_cnt  <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CNW'(1);
                if (iss_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_first <= (r_seen == SEEN_ONE);
            r_last  <= i_in_last;
            for (int j = 0; j < 3; j++) begin
                r_prev[j] <= r_older[j];
                r_p0[j]   <= r_newer[j];
                r_p3[j]   <= in_pt[j];
            end
        end
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_older[j] <= '0;
                r_newer[j] <= '0;
            end
        end else begin
            for (int j = 0; j < 3; j++) begin
                if (n_shift) begin
                    r_older[j] <= r_newer[j];
                end
                if (n_shift || n_buf) begin
                    r_newer[j] <= in_pt[j];
                end
            end
        end
    end

    // rounding, reciprocal quotient, correction and saturation
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sum[j] = (PW + 1)'(r_s2_pa[j]) + (PW + 1)'(r_s2_pb[j]);
            n_neg[j] = n_sum[j][PW];
            n_abs[j] = n_neg[j] ? (PW + 1)'(-n_sum[j]) : (PW + 1)'(n_sum[j]);
            n_mag[j] = n_abs[j][MW-1:0] + MW'(HDEN);

            n_acc[j] = ((2 * MW)'(r_s4_ph[j]) << LW) + (2 * MW)'(r_s4_pl[j]);
            n_qe[j]  = n_acc[j][MW +: QW];

            n_chk[j] = CW'(r_s5_qe[j]) * CW'(DEN);
            n_q[j]   = (n_chk[j] > CW'(r_s5_mag[j])) ? r_s5_qe[j] - QW'(1) : r_s5_qe[j];

            n_qs[j]  = r_neg[3][j] ? -$signed({1'b0, r_s6_q[j]}) : $signed({1'b0, r_s6_q[j]});
            n_tot[j] = (QW + 2)'(r_base[5][j]) + (QW + 2)'(n_qs[j]);
            if (n_tot[j][QW+1:W-1] == {(QW + 3 - W){n_tot[j][QW+1]}}) begin
                n_out[j] = n_tot[j][W-1:0];
            end else begin
                n_out[j] = n_tot[j][QW+1] ? SMIN : SMAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[5:0], r_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rl   <= {r_rl[5:0], iss_rl};
            r_pe   <= {r_pe[5:0], iss_pe};
            r_s1_a <= iss_a;
            r_s1_b <= iss_b;
            for (int k = 1; k < 6; k++) begin
                r_base[k] <= r_base[k-1];
            end
            for (int k = 1; k < 4; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            r_neg[0] <= n_neg;
            for (int j = 0; j < 3; j++) begin
                r_base[0][j] <= iss_from_p3 ? r_p3[j] : r_p0[j];
                r_s1_d03[j]  <= DW'(r_p3[j]) - DW'(r_p0[j]);
                r_s1_dp[j]   <= DW'(r_p3[j]) - DW'(r_prev[j]);
                r_s2_pa[j]   <= PW'(r_s1_a) * PW'(r_s1_d03[j]);
                r_s2_pb[j]   <= PW'(r_s1_b) * PW'(r_s1_dp[j]);
                r_s3_mag[j]  <= n_mag[j];
                r_s4_ph[j]   <= (HW + MW)'(r_s3_mag[j][MW-1:LW]) * (HW + MW)'(RECIP);
                r_s4_pl[j]   <= (LW + MW)'(r_s3_mag[j][LW-1:0]) * (LW + MW)'(RECIP);
                r_s4_mag[j]  <= r_s3_mag[j];
                r_s5_qe[j]   <= n_qe[j];
                r_s5_mag[j]  <= r_s4_mag[j];
                r_s6_q[j]    <= n_q[j];
                r_out[j]     <= n_out[j];
            end
        end
    end

    assign o_out_valid = r_vld[6];
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_run_last  = r_rl[6];
    assign o_path_end  = r_pe[6];

    a_last_restarts_path : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |=> (r_seen == SEEN_NONE))
        else $error("final point did not restart the path");

    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= CNW'(SAMPLES)))
        else $error("issue counter past the last result");

    a_end_is_run_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_path_end) |-> o_run_last)
        else $error("path end without run last");

endmodule

`default_nettype wire
